/* rtl/adcar_pkg.sv */
`default_nettype none

package adcar_pkg;

    // Group size and derived widths
    localparam int SAMPLES    = 5;
    localparam int SMP_W      = 16;
    localparam int SUM_W      = SMP_W + $clog2(SAMPLES);
    localparam int CNT_W      = $clog2(SAMPLES + 1);
    localparam int THR_W      = SUM_W + 1;
    localparam int GAIN_W     = 3;
    localparam int MULT_W     = 5;
    localparam int PM_W       = SUM_W + MULT_W;
    localparam int SCALE_W    = 32;
    localparam int PROD_W     = PM_W + SCALE_W;
    localparam int DIVISOR    = 128000 * SAMPLES;
    localparam int READ_W     = 40;
    localparam int HI_W       = 15;
    localparam int LO_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = ((GAIN_W + READ_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    // Group divisor split: 2^DIV_POW2 by shift, the rest by reciprocal multiply
    localparam int DIV_POW2   = 10;
    localparam int DIV_ODD    = DIVISOR / (2 ** DIV_POW2);
    localparam int NUM_W      = 32;
    localparam int RH_W       = $clog2(DIV_ODD);
    localparam int XL_W       = NUM_W - RH_W;
    localparam int X_W        = PROD_W - DIV_POW2;
    localparam int QH_W       = X_W - XL_W;
    localparam int RECIP_W    = NUM_W + 1;
    localparam int RECIP_SH   = NUM_W + RH_W;
    localparam int PRODR_W    = NUM_W + RECIP_W;
    localparam int QR_W       = PRODR_W - RECIP_SH;

    // ceil(2^RECIP_SH / DIV_ODD): exact floor division for any 32-bit numerator
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD));
    localparam logic [NUM_W-1:0]   DIV_ODD_C = NUM_W'(DIV_ODD);

    localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(5);

    // Result kinds
    localparam logic KIND_GAIN    = 1'b0;
    localparam logic KIND_READING = 1'b1;

    // Register reset values
    localparam logic [HI_W-1:0]           HI_THR_RST     = HI_W'(20000);
    localparam logic signed [LO_W-1:0]    LO_THR_RST     = LO_W'(7000);
    localparam logic [SCALE_W-1:0]        CUR_SCALE_RST  = SCALE_W'(655360000);
    localparam logic [SCALE_W-1:0]        VOLT_SCALE_RST = SCALE_W'(1730150);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_THR   = 2'd0,
        REG_LOW_THR    = 2'd1,
        REG_CUR_SCALE  = 2'd2,
        REG_VOLT_SCALE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [HI_W-1:0]        high_threshold;
        logic signed [LO_W-1:0] low_threshold;
        logic [SCALE_W-1:0]     current_scale;
        logic [SCALE_W-1:0]     voltage_scale;
    } cfg_t;

    // LSB weight per gain index, in units of 1/128000
    function automatic logic [MULT_W-1:0] lsb_mult(input logic [GAIN_W-1:0] g);
        logic [MULT_W-1:0] m;
        unique case (g)
            3'd0:    m = MULT_W'(24);
            3'd1:    m = MULT_W'(16);
            3'd2:    m = MULT_W'(8);
            3'd3:    m = MULT_W'(4);
            3'd4:    m = MULT_W'(2);
            default: m = MULT_W'(1);
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/adcar_cfg_regs.sv */
`default_nettype none

module adcar_cfg_regs
    import adcar_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register file write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_HIGH_THR:   cfg_next.high_threshold = cfg_data[HI_W-1:0];
                REG_LOW_THR:    cfg_next.low_threshold  = $signed(cfg_data[LO_W-1:0]);
                REG_CUR_SCALE:  cfg_next.current_scale  = cfg_data[SCALE_W-1:0];
                REG_VOLT_SCALE: cfg_next.voltage_scale  = cfg_data[SCALE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_threshold <= HI_THR_RST;
            cfg_reg.low_threshold  <= LO_THR_RST;
            cfg_reg.current_scale  <= CUR_SCALE_RST;
            cfg_reg.voltage_scale  <= VOLT_SCALE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/adcar_div.sv */
`default_nettype none

// Division by the fixed group divisor: drop the power-of-two part by shift, then
// divide by the remaining factor with one reciprocal multiplier used twice,
// first on the high part, then on the remainder joined with the low part.
module adcar_div
    import adcar_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    output logic                   done,
    output logic [READ_W-1:0]      quotient
);

    typedef enum logic [3:0] {
        DV_IDLE = 4'b0001,
        DV_HIGH = 4'b0010,
        DV_REM  = 4'b0100,
        DV_LOW  = 4'b1000
    } div_state_t;

    div_state_t         state_reg, state_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [XL_W-1:0]    low_reg, low_next;
    logic [QH_W-1:0]    qh_reg, qh_next;
    logic [READ_W-1:0]  quo_reg, quo_next;
    logic               done_reg, done_next;

    logic [PRODR_W-1:0] prod;
    logic [QR_W-1:0]    qr;
    logic [NUM_W-1:0]   rem_full;
    logic [X_W-1:0]     quo_full;

    // Shared reciprocal multiply
    assign prod     = PRODR_W'(num_reg) * PRODR_W'(RECIP_M);
    assign qr       = prod[RECIP_SH +: QR_W];
    assign rem_full = num_reg - NUM_W'(qh_reg) * DIV_ODD_C;
    assign quo_full = {qh_reg, qr[XL_W-1:0]};

    assign done     = done_reg;
    assign quotient = quo_reg;

    // Step sequencer
    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        low_next   = low_reg;
        qh_next    = qh_reg;
        quo_next   = quo_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    num_next   = NUM_W'(dividend[PROD_W-1 -: QH_W]);
                    low_next   = dividend[DIV_POW2 +: XL_W];
                    state_next = DV_HIGH;
                end
            end
            DV_HIGH:
            begin
                qh_next    = QH_W'(qr);
                state_next = DV_REM;
            end
            DV_REM:
            begin
                num_next   = {rem_full[RH_W-1:0], low_reg};
                state_next = DV_LOW;
            end
            DV_LOW:
            begin
                quo_next   = quo_full[READ_W-1:0];
                done_next  = 1'b1;
                state_next = DV_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        low_reg <= low_next;
        qh_reg  <= qh_next;
        quo_reg <= quo_next;
    end

endmodule

`default_nettype wire

/* rtl/adc_autorange_averager_top.sv */
`default_nettype none

// Channel   Handshake                 Payload
// s_*       s_tvalid / s_tready       tuser: channel; tdata: sample
// m_*       m_tvalid / m_tready       tuser: out_channel, kind; tdata: gain_index, reading
// cfg_*     cfg_valid / cfg_ready     cfg_index: register, cfg_data: value
//
// A sample that does not close a group is only accepted; a closing one also passes the judge state.
// A gain command then loads the output register; a settled range returns to idle with no output.
// A reading passes accept, judge, scale multiply, the divider's high, remainder and low steps, output load;
// the divider uses one reciprocal multiplier twice, for the high and low quotient parts.
// rst_n resets all channel state (gain index to GAIN_MAX) and loads register defaults; no clearing pass.
// s_tready is low while a group is in work or a result waits for the output register.
module adc_autorange_averager_top
    import adcar_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input beats
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [SMP_W-1:0]      s_tdata,   // [15:0] sample
    input  wire logic                  s_tuser,   // [0] channel
    // result beats
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [2:0] gain_index, [42:3] reading, rest 0
    output logic [OUT_USER_W-1:0]      m_tuser,   // [0] out_channel, [1] kind
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_JUDGE = 5'b00010,
        ST_SCALE = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    cfg_t cfg;

    state_t state_reg, state_next;

    // Per-channel state
    logic signed [SUM_W-1:0] sum_reg  [2];
    logic signed [SUM_W-1:0] sum_next [2];
    logic [CNT_W-1:0]        cnt_reg  [2];
    logic [CNT_W-1:0]        cnt_next [2];
    logic [GAIN_W-1:0]       gain_reg [2];
    logic [GAIN_W-1:0]       gain_next[2];
    logic                    conv_reg [2];
    logic                    conv_next[2];

    // Work registers
    logic                    ch_reg, ch_next;
    logic signed [SUM_W-1:0] work_sum_reg, work_sum_next;
    logic [PM_W-1:0]         pm_reg, pm_next;
    logic                    neg_reg, neg_next;
    logic                    res_kind_reg, res_kind_next;
    logic [GAIN_W-1:0]       res_gain_reg, res_gain_next;
    logic [READ_W-1:0]       res_read_reg, res_read_next;

    // Output register
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [OUT_USER_W-1:0]   m_tuser_reg, m_tuser_next;

    logic                    in_acc;
    logic                    out_load;
    logic signed [SUM_W-1:0] sum_add;
    logic [CNT_W-1:0]        cnt_inc;
    logic signed [THR_W-1:0] hi_lim, lo_lim, sum_ext;
    logic [GAIN_W-1:0]       gain_cur;
    logic                    go_down, go_up;
    logic [SUM_W-1:0]        mag;
    logic [SCALE_W-1:0]      scale_sel;
    logic                    div_start;
    logic [PROD_W-1:0]       dividend;
    logic                    div_done;
    logic [READ_W-1:0]       quotient;

    adcar_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adcar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .done     (div_done),
        .quotient (quotient)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // Accumulate
    assign sum_add = sum_reg[s_tuser] + SUM_W'($signed(s_tdata));
    assign cnt_inc = cnt_reg[s_tuser] + 1'b1;

    // Threshold tests on the group sum
    assign hi_lim   = $signed(THR_W'(cfg.high_threshold) * THR_W'(SAMPLES));
    assign lo_lim   = $signed(THR_W'(cfg.low_threshold) * THR_W'(SAMPLES));
    assign sum_ext  = THR_W'(work_sum_reg);
    assign gain_cur = gain_reg[ch_reg];
    assign go_down  = (sum_ext >= hi_lim) && (gain_cur != '0);
    assign go_up    = !go_down && (sum_ext <= lo_lim) && (gain_cur < GAIN_MAX);

    // Magnitude for the reading path
    assign mag = work_sum_reg[SUM_W-1] ? SUM_W'(-work_sum_reg) : work_sum_reg;

    // Scale multiply feeds the divider
    assign scale_sel = ch_reg ? cfg.voltage_scale : cfg.current_scale;
    assign dividend  = PROD_W'(pm_reg) * PROD_W'(scale_sel);
    assign div_start = (state_reg == ST_SCALE);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        gain_next     = gain_reg;
        conv_next     = conv_reg;
        ch_next       = ch_reg;
        work_sum_next = work_sum_reg;
        pm_next       = pm_reg;
        neg_next      = neg_reg;
        res_kind_next = res_kind_reg;
        res_gain_next = res_gain_reg;
        res_read_next = res_read_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    ch_next = s_tuser;
                    if (cnt_inc == CNT_W'(SAMPLES))
                    begin
                        sum_next[s_tuser] = '0;
                        cnt_next[s_tuser] = '0;
                        work_sum_next     = sum_add;
                        state_next        = ST_JUDGE;
                    end
                    else
                    begin
                        sum_next[s_tuser] = sum_add;
                        cnt_next[s_tuser] = cnt_inc;
                    end
                end
            end
            ST_JUDGE:
            begin
                res_gain_next = gain_cur;
                if (conv_reg[ch_reg])
                begin
                    conv_next[ch_reg] = 1'b0;
                    neg_next          = work_sum_reg[SUM_W-1];
                    pm_next           = PM_W'(mag) * PM_W'(lsb_mult(gain_cur));
                    res_kind_next     = KIND_READING;
                    state_next        = ST_SCALE;
                end
                else if (go_down || go_up)
                begin
                    gain_next[ch_reg] = go_down ? gain_cur - 1'b1 : gain_cur + 1'b1;
                    res_gain_next     = go_down ? gain_cur - 1'b1 : gain_cur + 1'b1;
                    res_kind_next     = KIND_GAIN;
                    res_read_next     = '0;
                    state_next        = ST_OUT;
                end
                else
                begin
                    conv_next[ch_reg] = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_read_next = neg_reg ? READ_W'(-quotient) : quotient;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Output stage
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_DATA_W'({res_read_reg, res_gain_reg});
            m_tuser_next  = {res_kind_reg, ch_reg};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Control and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < 2; c++)
            begin
                sum_reg[c]  <= '0;
                cnt_reg[c]  <= '0;
                gain_reg[c] <= GAIN_MAX;
                conv_reg[c] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            gain_reg     <= gain_next;
            conv_reg     <= conv_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        work_sum_reg <= work_sum_next;
        pm_reg       <= pm_next;
        neg_reg      <= neg_next;
        res_kind_reg <= res_kind_next;
        res_gain_reg <= res_gain_next;
        res_read_reg <= res_read_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // Checks
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (gain_reg[0] <= GAIN_MAX) && (gain_reg[1] <= GAIN_MAX))
        else $error("gain index out of range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] < CNT_W'(SAMPLES)) && (cnt_reg[1] < CNT_W'(SAMPLES)))
        else $error("sample count reached group size");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

    a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (res_kind_reg == KIND_GAIN)) |=> (m_tdata_reg[GAIN_W +: READ_W] == '0))
        else $error("gain command carries nonzero reading");

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
    import adcar_pkg::*;

    localparam logic CH_CURRENT    = 1'b0;
    localparam logic CH_VOLTAGE    = 1'b1;
    localparam int   SETTLE_CYCLES = 100;
    localparam int   HOLD_CYCLES   = 500;
    localparam int   LIMIT_CYCLES  = 500000;

    typedef struct packed {
        logic              channel;
        logic              kind;
        logic [GAIN_W-1:0] gain;
        logic [READ_W-1:0] reading;
    } report_t;

    // Per-channel gain and averaging tracker; holds the reports still owed by the block
    class autorange_tracker;
        bit [HI_W-1:0]         high_thr;
        bit signed [LO_W-1:0]  low_thr;
        bit [SCALE_W-1:0]      scale[2];
        bit signed [SUM_W-1:0] acc[2];
        bit [CNT_W-1:0]        taken[2];
        bit [GAIN_W-1:0]       gain[2];
        bit                    converting[2];
        int unsigned           lsb_weight[6];
        report_t               reports_due[$];
        int                    errors;

        function new();
            high_thr = HI_THR_RST;
            low_thr = LO_THR_RST;
            scale[CH_CURRENT] = CUR_SCALE_RST;
            scale[CH_VOLTAGE] = VOLT_SCALE_RST;
            lsb_weight = '{24, 16, 8, 4, 2, 1};
            errors = 0;
            for (int c = 0; c < 2; c++)
            begin
                acc[c] = '0;
                taken[c] = '0;
                gain[c] = GAIN_MAX;
                converting[c] = 1'b0;
            end
        endfunction

        function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_HIGH_THR:   high_thr = val[HI_W-1:0];
                REG_LOW_THR:    low_thr = val[LO_W-1:0];
                REG_CUR_SCALE:  scale[CH_CURRENT] = val;
                REG_VOLT_SCALE: scale[CH_VOLTAGE] = val;
                default: ;
            endcase
        endfunction

        // Accumulate one sample; a closing sample judges the group
        function void take_sample(logic ch, logic signed [SMP_W-1:0] smp);
            longint          total;
            longint unsigned mag;
            longint unsigned q;
            report_t         r;
            acc[ch] = acc[ch] + smp;
            taken[ch] = taken[ch] + 1'b1;
            if (taken[ch] < SAMPLES)
                return;
            total = acc[ch];
            acc[ch] = '0;
            taken[ch] = '0;
            r.channel = ch;
            r.reading = '0;
            r.gain = gain[ch];
            if (!converting[ch])
            begin
                // high test wins; at gain 0 fall through to the low test
                if (total >= longint'(high_thr) * SAMPLES && gain[ch] != 0)
                    gain[ch] = gain[ch] - 1'b1;
                else if (total <= longint'(low_thr) * SAMPLES && gain[ch] < GAIN_MAX)
                    gain[ch] = gain[ch] + 1'b1;
                else
                begin
                    // settled range: next group becomes a reading, nothing emitted
                    converting[ch] = 1'b1;
                    return;
                end
                r.kind = KIND_GAIN;
                r.gain = gain[ch];
            end
            else
            begin
                // magnitude scaled, truncated toward zero, sign restored
                mag = (total < 0) ? -total : total;
                q = mag * lsb_weight[gain[ch]] * scale[ch] / (64'd128000 * SAMPLES);
                r.kind = KIND_READING;
                r.reading = (total < 0) ? READ_W'(-q) : READ_W'(q);
                converting[ch] = 1'b0;
            end
            reports_due.push_back(r);
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (reports_due.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: ch=%0d kind=%0d gain=%0d reading=%0d",
                         $time, got.channel, got.kind, got.gain, $signed(got.reading));
                errors++;
                return;
            end
            want = reports_due.pop_front();
            if (got.channel !== want.channel)
            begin
                $display("%0t: out_channel expected %0d actual %0d", $time, want.channel, got.channel);
                errors++;
            end
            if (got.kind !== want.kind)
            begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.gain !== want.gain)
            begin
                $display("%0t: gain_index expected %0d actual %0d", $time, want.gain, got.gain);
                errors++;
            end
            if (got.reading !== want.reading)
            begin
                $display("%0t: reading expected %0d actual %0d", $time,
                         $signed(want.reading), $signed(got.reading));
                errors++;
            end
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

    // Clock, reset and block inputs, all known from time zero
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SMP_W-1:0]       s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [OUT_USER_W-1:0]  m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    reg_idx_t               cfg_index = REG_HIGH_THR;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    autorange_tracker       tracker;
    bit                     src_eager = 1'b0;
    bit                     snk_eager = 1'b0;
    int                     results_seen = 0;

    // Sample generator view: thresholds in force and per-channel group shaping
    bit [HI_W-1:0]          gen_high = HI_THR_RST;
    bit signed [LO_W-1:0]   gen_low = LO_THR_RST;
    int                     level[2];
    int                     spread[2];
    int                     mode[2];
    int                     placed[2] = '{0, 0};

    always #10 clk = ~clk;

    adc_autorange_averager_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Groups aim at a band around the thresholds; mode 9 is plain noise
    function automatic logic [SMP_W-1:0] draw_sample(input logic ch);
        int v;
        if (placed[ch] == 0)
        begin
            mode[ch] = $urandom_range(0, 9);
            spread[ch] = $urandom_range(0, 300);
            case (mode[ch])
                0, 1, 2: level[ch] = pick(int'(gen_high), 32767);
                3, 4:    level[ch] = pick(-32768, int'(gen_low));
                5, 6:    level[ch] = (int'(gen_high) - int'(gen_low) > 2) ?
                                     pick(int'(gen_low) + 1, int'(gen_high) - 1) :
                                     pick(-32768, 32767);
                7:       level[ch] = int'(gen_high);
                8:       level[ch] = int'(gen_low);
                default: level[ch] = 0;
            endcase
            if (mode[ch] == 7 || mode[ch] == 8)
                spread[ch] = 0;
        end
        placed[ch] = (placed[ch] + 1) % SAMPLES;
        if (mode[ch] == 9)
            v = pick(-32768, 32767);
        else
            v = level[ch] + pick(-spread[ch], spread[ch]);
        // exact-threshold groups: last sample lands the sum on, just under or just over
        if ((mode[ch] == 7 || mode[ch] == 8) && placed[ch] == 0)
            v = v + pick(-1, 1);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return SMP_W'(v);
    endfunction

    // Offer one sample beat; tvalid stays high for a back-to-back follower
    task automatic push_sample(input logic ch, input logic [SMP_W-1:0] smp);
        int gap;
        gap = src_eager ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tuser <= ch;
        do @(posedge clk); while (!s_tready);
        tracker.take_sample(ch, smp);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_reg(idx, val);
    endtask

    task automatic configure(input logic [HI_W-1:0] hi, input logic signed [LO_W-1:0] lo,
                             input logic [SCALE_W-1:0] cur, input logic [SCALE_W-1:0] volt);
        write_reg(REG_HIGH_THR, CFG_DATA_W'(hi));
        write_reg(REG_LOW_THR, CFG_DATA_W'(lo));
        write_reg(REG_CUR_SCALE, cur);
        write_reg(REG_VOLT_SCALE, volt);
        cfg_valid <= 1'b0;
        gen_high = hi;
        gen_low = lo;
    endtask

    // Wait out every owed report, then the judge of a silent closing group
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int n);
        logic ch;
        for (int i = 0; i < n; i++)
        begin
            ch = 1'($urandom_range(0, 1));
            push_sample(ch, draw_sample(ch));
        end
        settle();
    endtask

    // Main sequence
    initial
    begin : stimulus
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale positive on current lowers gain while voltage builds a
        // full-scale negative group that cannot raise gain past the narrowest range
        for (int i = 0; i < 5; i++)
        begin
            push_sample(CH_CURRENT, 16'h7FFF);
            push_sample(CH_VOLTAGE, 16'h8000);
        end
        // voltage now converting: negative full-scale reading
        for (int i = 0; i < 5; i++)
            push_sample(CH_VOLTAGE, 16'h8000);
        // average exactly at the high threshold, then exactly at the low one
        for (int i = 0; i < 5; i++)
            push_sample(CH_CURRENT, SMP_W'(20000));
        for (int i = 0; i < 5; i++)
            push_sample(CH_CURRENT, SMP_W'(7000));
        settle();

        run_phase(250);

        // extreme settings: everything non-negative lowers gain, widest scales
        src_eager = 1'b1;
        configure(15'd0, -16'sd32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(240);

        // both thresholds at the top, zero scales
        src_eager = 1'b0;
        snk_eager = 1'b1;
        configure(15'd32767, 16'sd32767, 32'd0, 32'd0);
        run_phase(240);

        snk_eager = 1'b0;
        configure(HI_W'($urandom), LO_W'($urandom), $urandom, $urandom);
        run_phase(240);

        configure(HI_W'($urandom), LO_W'($urandom), $urandom, $urandom);
        run_phase(240);

        configure(15'd1000, -16'sd1000, CUR_SCALE_RST, VOLT_SCALE_RST);
        run_phase(240);

        if (tracker.errors == 0)
            $display("** adc_autorange_averager_top: PASSED **");
        else
            $display("** adc_autorange_averager_top: FAILED **");
        $finish;
    end

    // Result side: random stalls, two long hold-offs to back up the input
    initial
    begin : sink
        int      stall;
        report_t got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = snk_eager ? 0 : $urandom_range(0, 10);
            if (results_seen == 40 || results_seen == 150)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.channel = m_tuser[0];
            got.kind = m_tuser[1];
            got.gain = m_tdata[GAIN_W-1:0];
            got.reading = m_tdata[GAIN_W +: READ_W];
            results_seen++;
            tracker.check_report(got);
        end
    end

    // Watchdog
    initial
    begin : watchdog
        #(20 * LIMIT_CYCLES);
        $display("** adc_autorange_averager_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

/* adc_autorange_averager_top.f */
rtl/adcar_pkg.sv
rtl/adcar_cfg_regs.sv
rtl/adcar_div.sv
rtl/adc_autorange_averager_top.sv
tb/tb.sv
